// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the rasteriser RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/gcr_pkg.sv -----
// ---------------------------------------------------------------------------
// gcr_pkg
// Types, constants and the 5x7 font ROM for the glyph cell rasteriser.
// ---------------------------------------------------------------------------
package gcr_pkg;

   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;
   localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
   localparam int ROM_ROW_BITS = 8;
   localparam int FONT_SIZE = 96;

   localparam logic [7:0] FONT_FIRST = 8'd32;
   localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);
   localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);

   // Stream payload widths (whole bytes)
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 64;

   // Packed glyph: bit (row*5 + col), row 0 column 0 lowest
   typedef logic [GLYPH_BITS-1:0] glyph_type;

   // One character held between the input register and the cell walker
   typedef struct packed {
      glyph_type   glyph;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [31:0] fore_color;
      logic [31:0] back_color;
   } item_type;

   // Font for codes 32..127, 7 rows of 8 bits, low 5 bits used
   localparam logic [55:0] FONT_ROM [FONT_SIZE] = '{
      56'h00000000000000, 56'h00040004040404, 56'h00000000000a0a, 56'h0a0a1f0a1f0a0a,
      56'h040e140e050e04, 56'h00191a040b1300, 56'h16091502050502, 56'h00000000000404,
      56'h08040202020408, 56'h02040808080402, 56'h00000a040a0000, 56'h0004041f040400,
      56'h01020000000000, 56'h0000000e000000, 56'h00060600000000, 56'h01020204080810,
      56'h0c12121212120c, 56'h1c080808080c08, 56'h1e02021c10100e, 56'h06080806080806,
      56'h08081f090a0408, 56'h040a080602020e, 56'h0c12120e02020c, 56'h0404040808101e,
      56'h0c12120c12120c, 56'h0408101c12120c, 56'h06060000000606, 56'h0404040000040c,
      56'h00080402040800, 56'h00000e000e0000, 56'h00020408040200, 56'h0400040810120c,
      56'h1e011d151d110e, 56'h11110e0a0a0404, 56'h0e12120e12120e, 56'h0c02020202020c,
      56'h060a1212120a06, 56'h0e02020e02020e, 56'h0202020e02021e, 56'h0e11151d01010e,
      56'h1212121e121212, 56'h0e04040404040e, 56'h040a0808080808, 56'h11090502050911,
      56'h0e020202020202, 56'h11111115151b11, 56'h11110915121100, 56'h0e111111110e00,
      56'h0202021e12121e, 56'h16091511110e00, 56'h11110907090907, 56'h0c12100e02120c,
      56'h0404040404041f, 56'h0c121212121200, 56'h04040a11110000, 56'h0a0a0a15151511,
      56'h11110a040a1100, 56'h04040404040a11, 56'h1f01020408100f, 56'h0e02020202020e,
      56'h08080804040202, 56'h0e08080808080e, 56'h000000000a0400, 56'h1e000000000000,
      56'h00000000080400, 56'h000c121c100c00, 56'h000c12120e0202, 56'h00180404041800,
      56'h000c12121c1010, 56'h000c020e120c00, 56'h0004040c040418, 56'h0e101e12120c00,
      56'h001212120e0202, 56'h00080808000800, 56'h08141010001000, 56'h0014140c140400,
      56'h000c0404040400, 56'h0011151b0a0000, 56'h001212120c0000, 56'h000c12120c0000,
      56'h020e12120c0000, 56'h101c12120c0000, 56'h00040404140800, 56'h00060806020c00,
      56'h081404041e0404, 56'h000e0a0a0a0000, 56'h00040a0a0a0000, 56'h000a1515110000,
      56'h000a04040a0000, 56'h02040814120000, 56'h000e04080e0000, 56'h0c02020102020c,
      56'h00040404040400, 56'h06080810080806, 56'h00000815020000, 56'h0a150a150a150a
   };

   // Codes 32..127 have a glyph
   function automatic logic gcr_code_drawn(input logic [7:0] code);
      return (code[7] == 1'b0) && (code[6:5] != 2'b00);
   endfunction

   // ROM lookup, dropping the three unused columns of each row
   function automatic glyph_type gcr_font_lookup(input logic [7:0] code);
      logic [6:0]  idx;
      logic [55:0] word;
      glyph_type   g;
      idx  = code[6:0] - FONT_FIRST[6:0];
      word = '0;
      if (gcr_code_drawn(code)) begin
         word = FONT_ROM[idx];
      end
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         g[r*GLYPH_COLS +: GLYPH_COLS] = word[r*ROM_ROW_BITS +: GLYPH_COLS];
      end
      return g;
   endfunction

endpackage

// ----- rtl/gcr_in_stage.sv -----
// ---------------------------------------------------------------------------
// gcr_in_stage
// Input register: unpacks a request, looks up its glyph and holds it for
// the cell walker. Codes without a glyph are taken and dropped.
// ---------------------------------------------------------------------------
module gcr_in_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // char_code[7:0], origin_x[23:8], origin_y[39:24],
   // fore_color[71:40], back_color[103:72]
   input  logic [gcr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           take,
   output logic                           item_valid,
   output gcr_pkg::item_type              item
);
   import gcr_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   logic     drawn;

   // Free when empty or when the walker takes the held item this cycle
   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;
   assign drawn      = gcr_code_drawn(req_tdata[7:0]);

   // Next-state logic
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = drawn;
         item_in.glyph      = gcr_font_lookup(req_tdata[7:0]);
         item_in.origin_x   = req_tdata[23:8];
         item_in.origin_y   = req_tdata[39:24];
         item_in.fore_color = req_tdata[71:40];
         item_in.back_color = req_tdata[103:72];
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/gcr_cell_walker.sv -----
// ---------------------------------------------------------------------------
// gcr_cell_walker
// Walks the 35 cells of one glyph row-major into the result register, one per
// cycle while it is not stalled. Cell corners come from running sums of the scale.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gcr_cell_walker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [7:0]                     glyph_scale,
   input  logic                           item_valid,
   input  gcr_pkg::item_type              item,
   output logic                           take,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cell_x[15:0], cell_y[31:16], cell_color[63:32]
   output logic [gcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // cell_lit[0]
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);
   import gcr_pkg::*;

   // Walk state
   logic        busy_ff, busy_in;
   logic [2:0]  row_ff, row_in;
   logic [2:0]  col_ff, col_in;
   glyph_type   glyph_ff, glyph_in;
   logic [15:0] ox_ff, ox_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] y_ff, y_in;
   logic [31:0] fg_ff, fg_in;
   logic [31:0] bg_ff, bg_in;

   // Result register
   logic                  rvalid_ff, rvalid_in;
   logic [RSP_DATA_W-1:0] rdata_ff, rdata_in;
   logic                  rlit_ff, rlit_in;
   logic                  rlast_ff, rlast_in;

   logic        advance;
   logic        cell_last;
   logic        load;
   logic [15:0] scale_ext;

   assign scale_ext = {8'd0, glyph_scale};
   assign cell_last = (row_ff == LAST_ROW) && (col_ff == LAST_COL);
   assign advance   = busy_ff && (!rvalid_ff || rsp_tready);
   assign take      = !busy_ff || (advance && cell_last);
   assign load      = take && item_valid;

   // Cell sequencing
   always_comb begin
      busy_in  = busy_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      glyph_in = glyph_ff;
      ox_in    = ox_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      if (advance) begin
         glyph_in = glyph_ff >> 1;
         if (col_ff == LAST_COL) begin
            col_in = 3'd0;
            row_in = row_ff + 3'd1;
            x_in   = ox_ff;
            y_in   = y_ff + scale_ext;
         end else begin
            col_in = col_ff + 3'd1;
            x_in   = x_ff + scale_ext;
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         row_in   = 3'd0;
         col_in   = 3'd0;
         glyph_in = item.glyph;
         ox_in    = item.origin_x;
         x_in     = item.origin_x;
         y_in     = item.origin_y;
         fg_in    = item.fore_color;
         bg_in    = item.back_color;
      end else if (take) begin
         busy_in = 1'b0;
         row_in  = 3'd0;
         col_in  = 3'd0;
      end
   end

   // Result register: refilled on advance, emptied when taken
   always_comb begin
      rvalid_in = rvalid_ff;
      rdata_in  = rdata_ff;
      rlit_in   = rlit_ff;
      rlast_in  = rlast_ff;
      if (advance) begin
         rvalid_in = 1'b1;
         rlit_in   = glyph_ff[0];
         rlast_in  = cell_last;
         rdata_in  = {(glyph_ff[0] ? fg_ff : bg_ff), y_ff, x_ff};
      end else if (rsp_tready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         row_ff    <= 3'd0;
         col_ff    <= 3'd0;
         rvalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         rvalid_ff <= rvalid_in;
      end
      glyph_ff <= glyph_in;
      ox_ff    <= ox_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      fg_ff    <= fg_in;
      bg_ff    <= bg_in;
      rdata_ff <= rdata_in;
      rlit_ff  <= rlit_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = rlit_ff;
   assign rsp_tlast  = rlast_ff;

   // Checks
   `ASSERT_PROP(a_pos_range, clock, reset, !busy_ff || ((row_ff <= LAST_ROW) && (col_ff <= LAST_COL)), "cell position out of glyph")
   `ASSERT_NEXT(a_wrap_after_last, clock, reset, advance && cell_last, (row_ff == 3'd0) && (col_ff == 3'd0), "walk did not restart after last cell")
   `ASSERT_IMPLY(a_x_row_start, clock, reset, busy_ff && (col_ff == 3'd0), x_ff == ox_ff, "row does not start at origin column")
   `ASSERT_IMPLY(a_fall_on_take, clock, reset, $fell(rsp_tvalid), $past(rsp_tready), "result dropped without being taken")

endmodule

// ----- rtl/glyph_cell_rasterizer.sv -----
// ---------------------------------------------------------------------------
// glyph_cell_rasterizer
// 5x7 bitmap font character generator: one request in, 35 glyph cells out.
//
//   Channel | Dir | Handshake              | Payload
//   req_*   | in  | req_tvalid/req_tready  | code, origin, fore/back colour
//   rsp_*   | out | rsp_tvalid/rsp_tready  | cell corner, colour; lit, last
//   csr_*   | in  | csr_valid/csr_ready    | glyph_scale (8 bits)
//
// A drawable character gives 35 cells, one per cycle when results do not stall,
// so the cell walker sets the rate. A request passes the input register, the
// walker state and the result register. Codes outside 32..127 are taken and dropped.
// Reset sets glyph_scale to 1 and empties every stage.
// A stalled result holds the walker; the input register still takes one item.
// ---------------------------------------------------------------------------
module glyph_cell_rasterizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // char_code[7:0], origin_x[23:8], origin_y[39:24],
   // fore_color[71:40], back_color[103:72]
   input  logic [gcr_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cell_x[15:0], cell_y[31:16], cell_color[63:32]
   output logic [gcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // cell_lit[0]
   output logic                           rsp_tuser,
   // last_cell
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [7:0]                     csr_data
);
   import gcr_pkg::*;

   logic [7:0] scale_ff, scale_in;
   logic       take;
   logic       item_valid;
   item_type   item;

   // Scale register, always writable
   assign csr_ready = 1'b1;

   always_comb begin
      scale_in = scale_ff;
      if (csr_valid && csr_ready) begin
         scale_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 8'd1;
      end else begin
         scale_ff <= scale_in;
      end
   end

   gcr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   gcr_cell_walker u_cell_walker (
      .clock       (clock),
      .reset       (reset),
      .glyph_scale (scale_ff),
      .item_valid  (item_valid),
      .item        (item),
      .take        (take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ----- sim/glyph_cell_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph cell checker
// Watches the request, result and register channels of the glyph cell
// rasteriser. It works out the 35 expected cells of every drawable character
// from its own font table and scale copy, and compares each cell it sees.
// ----------------------------------------------------------------------------
module glyph_cell_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // char_code, origin_x, origin_y, fore_color, back_color
   input  logic [gcr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cell_x, cell_y, cell_color
   input  logic [gcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // cell_lit
   input  logic                           rsp_tuser,
   // last_cell
   input  logic                           rsp_tlast,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [7:0]                     csr_data,
   output int                             cells_pending,
   output int                             fault_count
);
   import gcr_pkg::*;

   localparam int          ROW_STRIDE = 8;
   localparam logic [8:0]  FONT_END   = 9'd128;

   typedef struct packed {
      logic [15:0] cell_x;
      logic [15:0] cell_y;
      logic [31:0] cell_color;
      logic        cell_lit;
      logic        last_cell;
   } glyph_cell_type;

   // 5x7 font for codes 32..127, row r in bits [8r+4:8r]
   localparam logic [55:0] GLYPH_WORDS [96] = '{
      56'h00000000000000, 56'h00040004040404, 56'h00000000000a0a, 56'h0a0a1f0a1f0a0a,
      56'h040e140e050e04, 56'h00191a040b1300, 56'h16091502050502, 56'h00000000000404,
      56'h08040202020408, 56'h02040808080402, 56'h00000a040a0000, 56'h0004041f040400,
      56'h01020000000000, 56'h0000000e000000, 56'h00060600000000, 56'h01020204080810,
      56'h0c12121212120c, 56'h1c080808080c08, 56'h1e02021c10100e, 56'h06080806080806,
      56'h08081f090a0408, 56'h040a080602020e, 56'h0c12120e02020c, 56'h0404040808101e,
      56'h0c12120c12120c, 56'h0408101c12120c, 56'h06060000000606, 56'h0404040000040c,
      56'h00080402040800, 56'h00000e000e0000, 56'h00020408040200, 56'h0400040810120c,
      56'h1e011d151d110e, 56'h11110e0a0a0404, 56'h0e12120e12120e, 56'h0c02020202020c,
      56'h060a1212120a06, 56'h0e02020e02020e, 56'h0202020e02021e, 56'h0e11151d01010e,
      56'h1212121e121212, 56'h0e04040404040e, 56'h040a0808080808, 56'h11090502050911,
      56'h0e020202020202, 56'h11111115151b11, 56'h11110915121100, 56'h0e111111110e00,
      56'h0202021e12121e, 56'h16091511110e00, 56'h11110907090907, 56'h0c12100e02120c,
      56'h0404040404041f, 56'h0c121212121200, 56'h04040a11110000, 56'h0a0a0a15151511,
      56'h11110a040a1100, 56'h04040404040a11, 56'h1f01020408100f, 56'h0e02020202020e,
      56'h08080804040202, 56'h0e08080808080e, 56'h000000000a0400, 56'h1e000000000000,
      56'h00000000080400, 56'h000c121c100c00, 56'h000c12120e0202, 56'h00180404041800,
      56'h000c12121c1010, 56'h000c020e120c00, 56'h0004040c040418, 56'h0e101e12120c00,
      56'h001212120e0202, 56'h00080808000800, 56'h08141010001000, 56'h0014140c140400,
      56'h000c0404040400, 56'h0011151b0a0000, 56'h001212120c0000, 56'h000c12120c0000,
      56'h020e12120c0000, 56'h101c12120c0000, 56'h00040404140800, 56'h00060806020c00,
      56'h081404041e0404, 56'h000e0a0a0a0000, 56'h00040a0a0a0000, 56'h000a1515110000,
      56'h000a04040a0000, 56'h02040814120000, 56'h000e04080e0000, 56'h0c02020102020c,
      56'h00040404040400, 56'h06080810080806, 56'h00000815020000, 56'h0a150a150a150a
   };

   glyph_cell_type expected_cells [$];
   glyph_cell_type want;
   glyph_cell_type got;
   logic [7:0]     scale_copy;
   int             faults;

   // Queue the 35 cells of one character, row-major; other codes draw nothing
   task automatic predict_cells(input logic [REQ_DATA_W-1:0] item);
      logic [7:0]     code;
      logic [15:0]    origin_x;
      logic [15:0]    origin_y;
      logic [31:0]    fore_color;
      logic [31:0]    back_color;
      logic [6:0]     idx;
      logic [55:0]    word;
      logic [31:0]    pos_x;
      logic [31:0]    pos_y;
      glyph_cell_type exp_cell;
      code       = item[7:0];
      origin_x   = item[23:8];
      origin_y   = item[39:24];
      fore_color = item[71:40];
      back_color = item[103:72];
      if ({1'b0, code} < {1'b0, FONT_FIRST} || {1'b0, code} >= FONT_END) begin
         return;
      end
      idx  = 7'(code - FONT_FIRST);
      word = GLYPH_WORDS[idx];
      for (int row = 0; row < GLYPH_ROWS; row++) begin
         for (int col = 0; col < GLYPH_COLS; col++) begin
            pos_x               = origin_x + col * scale_copy;
            pos_y               = origin_y + row * scale_copy;
            exp_cell.cell_x     = pos_x[15:0];
            exp_cell.cell_y     = pos_y[15:0];
            exp_cell.cell_lit   = word[row * ROW_STRIDE + col];
            exp_cell.cell_color = exp_cell.cell_lit ? fore_color : back_color;
            exp_cell.last_cell  = (row == GLYPH_ROWS - 1) && (col == GLYPH_COLS - 1);
            expected_cells.push_back(exp_cell);
         end
      end
   endtask

   // Track the scale, predict on each request, compare each cell
   always @(posedge clock) begin
      if (reset) begin
         expected_cells.delete();
         scale_copy = 8'd1;
      end else begin
         if (csr_valid && csr_ready) begin
            scale_copy = csr_data;
         end
         if (req_tvalid && req_tready) begin
            predict_cells(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[63:32],
                    rsp_tuser, rsp_tlast};
            if (expected_cells.size() == 0) begin
               $error("cell item with none expected: x %h y %h colour %h",
                      got.cell_x, got.cell_y, got.cell_color);
               faults++;
            end else begin
               want = expected_cells.pop_front();
               if (got.cell_x != want.cell_x) begin
                  $error("cell_x: expected %h, got %h", want.cell_x, got.cell_x);
                  faults++;
               end
               if (got.cell_y != want.cell_y) begin
                  $error("cell_y: expected %h, got %h", want.cell_y, got.cell_y);
                  faults++;
               end
               if (got.cell_color != want.cell_color) begin
                  $error("cell_color: expected %h, got %h",
                         want.cell_color, got.cell_color);
                  faults++;
               end
               if (got.cell_lit !== want.cell_lit) begin
                  $error("cell_lit: expected %b, got %b", want.cell_lit, got.cell_lit);
                  faults++;
               end
               if (got.last_cell !== want.last_cell) begin
                  $error("last_cell: expected %b, got %b",
                         want.last_cell, got.last_cell);
                  faults++;
               end
            end
         end
      end
      cells_pending <= expected_cells.size();
      fault_count   <= faults;
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph cell rasteriser testbench
// Drives characters and scale settings into the rasteriser with random gaps
// and result stalls; the checker beside the block predicts and compares every
// cell. Phases run at scale 1, 255, 0, a random scale and small scales.
// ----------------------------------------------------------------------------
module testbench;
   import gcr_pkg::*;

   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         TAIL_CYCLES  = 40;
   localparam int         IDLE_PERCENT = 27;
   localparam logic [7:0] FONT_LAST    = 8'd127;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [7:0]            csr_data   = '0;
   logic                  steady     = 1'b0;
   int                    cells_pending;
   int                    fault_count;
   int                    cycle_count;

   always #6 clock = ~clock;

   glyph_cell_rasterizer uut (.*);

   glyph_cell_checker cell_check (.*);

   // Result side: random stalls, none during a steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL glyph_cell_rasterizer");
      $finish;
   end

   // Offer one character after a random gap and wait for it to be taken
   task automatic send_char(input logic [7:0] code, input logic [15:0] origin_x,
                            input logic [15:0] origin_y, input logic [31:0] fore_color,
                            input logic [31:0] back_color);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {back_color, fore_color, origin_y, origin_x, code};
      do @(posedge clock); while (!req_tready);
   endtask

   // Random characters, count items in all, some of them without a glyph
   task automatic send_random_chars(input int count);
      int          sent;
      int          pick;
      logic [7:0]  code;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            code = 8'($urandom_range(FONT_FIRST, FONT_LAST));
         end else if (pick < 92) begin
            code = 8'($urandom_range(0, FONT_FIRST - 1));
         end else begin
            code = 8'($urandom_range(FONT_LAST + 1, 255));
         end
         origin_x = ($urandom_range(7) == 0) ? 16'hFFFF - 16'($urandom_range(40))
                                              : 16'($urandom_range(65535));
         origin_y = ($urandom_range(7) == 0) ? 16'hFFFF - 16'($urandom_range(40))
                                              : 16'($urandom_range(65535));
         send_char(code, origin_x, origin_y, $urandom, $urandom);
         sent++;
      end
   endtask

   // Wait for every expected cell, then let a dropped character clear
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cells_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_glyph_scale(input logic [7:0] scale);
      csr_valid <= 1'b1;
      csr_data  <= scale;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset scale: font edges, blank and checkerboard glyphs, dropped codes
      send_char(8'd32, 16'h0000, 16'h0000, 32'hFFFFFFFF, 32'h00000000);
      send_char(8'd127, 16'h0010, 16'h0020, 32'h00000000, 32'hFFFFFFFF);
      send_char(8'd65, 16'h0000, 16'h0000, 32'h12345678, 32'h9ABCDEF0);
      send_char(8'd31, 16'h1111, 16'h2222, 32'h0BADF00D, 32'h0BADF00D);
      send_char(8'd0, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000);
      send_char(8'd128, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_char(8'd255, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_char(8'd48, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'h00000000);
      send_char(8'd33, 16'hFFFE, 16'hFFFC, 32'hA5A5A5A5, 32'h5A5A5A5A);
      send_char(8'd93, 16'h8000, 16'h7FFF, 32'h00FF00FF, 32'hFF00FF00);
      send_random_chars(70);

      // Full scale: cell corners wrap past 65535
      settle();
      write_glyph_scale(8'd255);
      send_char(8'd65, 16'hFF00, 16'hFFF0, 32'hCAFEBABE, 32'h01234567);
      send_char(8'd127, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'h00000000);
      send_char(8'd200, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000);
      send_char(8'd87, 16'hFC05, 16'hFA00, 32'h0F0F0F0F, 32'hF0F0F0F0);
      send_random_chars(60);

      // Zero scale: every cell sits on the origin
      settle();
      write_glyph_scale(8'd0);
      send_char(8'd35, 16'h1234, 16'hABCD, 32'h11111111, 32'h22222222);
      send_char(8'd64, 16'hFFFF, 16'h0000, 32'h33333333, 32'h44444444);
      send_random_chars(60);

      // Random scale, no gaps or stalls on either side
      settle();
      steady <= 1'b1;
      write_glyph_scale(8'($urandom_range(1, 254)));
      send_random_chars(70);

      // Small scales with idling again
      settle();
      steady <= 1'b0;
      write_glyph_scale(8'($urandom_range(2, 8)));
      send_random_chars(70);

      settle();
      write_glyph_scale(8'd1);
      send_random_chars(70);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0 && cells_pending == 0) begin
         $display("PASS glyph_cell_rasterizer");
      end else begin
         $display("FAIL glyph_cell_rasterizer");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/gcr_pkg.sv
rtl/gcr_in_stage.sv
rtl/gcr_cell_walker.sv
rtl/glyph_cell_rasterizer.sv
sim/glyph_cell_checker.sv
sim/testbench.sv
